[rtl/core/kwm_pkg.sv]
// Shared constants, types and codes of the k-way sorted merge.
`timescale 1ns / 1ps

package kwm_pkg;

    // Defaults for the top level parameters
    localparam int DEF_MAX_LISTS   = 8;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_VALUE_BITS  = 32;

    // Width of a list count, enough for up to 16 lists
    localparam int ACT_W = 5;

    // Results one input item may release, and the width of their count
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ENDED    = 2'd2,
        STAT_INACTIVE = 2'd3
    } status_t;

    // Control of the shared compare unit
    typedef struct packed {
        logic start;   // forget the running minimum
        logic cmp_en;  // compare the head that arrives from the queue memory
    } min_ctrl_t;

endpackage

[rtl/core/kwm_queue_mem.sv]
// Queue storage for all lists: one write port, one registered read port.
`timescale 1ns / 1ps

module kwm_queue_mem
    import kwm_pkg::*;
#(
    parameter int ENTRIES    = DEF_MAX_LISTS * DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int ADDR_W     = $clog2(ENTRIES)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [ENTRIES];
    logic [VALUE_BITS-1:0] rd_data_reg;

    // Store an element
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read a queue head
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/kwm_min_unit.sv]
// Shared compare unit: keeps the running minimum over the scanned queue heads.
`timescale 1ns / 1ps

module kwm_min_unit
    import kwm_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int LIST_W     = $clog2(DEF_MAX_LISTS)
) (
    input  logic                         aclk,
    input  min_ctrl_t                    ctrl,
    input  logic [LIST_W-1:0]            cmp_list,
    input  logic signed [VALUE_BITS-1:0] cmp_value,
    output logic                         any,
    output logic [LIST_W-1:0]            best_list,
    output logic signed [VALUE_BITS-1:0] best_value
);

    logic                         any_reg, any_next;
    logic [LIST_W-1:0]            list_reg, list_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;

    // Take a head only if strictly smaller, so the lower list wins a tie
    always_comb begin
        any_next   = any_reg;
        list_next  = list_reg;
        value_next = value_reg;
        if (ctrl.start) begin
            any_next = 1'b0;
        end else if (ctrl.cmp_en && (!any_reg || (cmp_value < value_reg))) begin
            any_next   = 1'b1;
            list_next  = cmp_list;
            value_next = cmp_value;
        end
    end

    always_ff @(posedge aclk) begin
        any_reg   <= any_next;
        list_reg  <= list_next;
        value_reg <= value_next;
    end

    assign any        = any_reg;
    assign best_list  = list_reg;
    assign best_value = value_reg;

endmodule

[rtl/core/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge: queue control, scan sequencer, result register.
//
// Usage
//   Input items arrive on the s_ channel: tdata carries list_id and value, tuser
//   flags has_value, tlast marks end_of_list. An accepted element joins its list's queue.
//   Results leave on the m_ channel: tdata carries out_value and source_list, tuser
//   carries out_valid and status, tlast marks the final merge_done result.
//   cfg_we/cfg_wdata write active_lists; write it only while the block is idle.
// Flow
//   An item is taken while s_tready is high; s_tready then stays low until its work
//   is done. A rejected item first posts its status in S_STATUS, ahead of any scan.
//   Every emission, and the final check, costs one scan of the active lists with the
//   shared compare unit: one head read per list in S_SCAN, S_LAST for the registered
//   queue read of the last head, then S_DECIDE to emit or stop. At most 64 results
//   per item.
// Reset and stall
//   aresetn clears the queues, end flags and the output valid flag and sets
//   active_lists to 8; queue memory contents are left as they are.
//   A stalled m_tready holds the current result; the sequencer waits before
//   loading the next one, but a new item is taken while the last result waits.
`timescale 1ns / 1ps

module k_way_sorted_merge
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS   = DEF_MAX_LISTS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // active_lists
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,        // [2:0] list_id, [34:3] value, [39:35] zero
    input  logic        s_tuser,        // [0] has_value
    input  logic        s_tlast,        // end_of_list
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // [31:0] out_value, [34:32] source_list, [39:35] zero
    output logic [2:0]  m_tuser,        // [0] out_valid, [2:1] status
    output logic        m_tlast         // merge_done
);

    localparam int LIST_W  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = MAX_LISTS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STATUS,
        S_SCAN,
        S_LAST,
        S_DECIDE
    } state_t;

    // Input fields
    logic [2:0]  in_list;
    logic [31:0] in_value;
    logic        in_has_value;
    logic        in_eol;

    assign in_list      = s_tdata[2:0];
    assign in_value     = s_tdata[34:3];
    assign in_has_value = s_tuser;
    assign in_eol       = s_tlast;

    // Configuration register
    logic [3:0] active_lists_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_lists_reg <= 4'd8;
        end else if (cfg_we) begin
            active_lists_reg <= cfg_wdata;
        end
    end

    // Clamp the list count to 1..MAX_LISTS
    logic [ACT_W-1:0] act_count;
    logic [ACT_W-1:0] cfg_ext;

    assign cfg_ext = ACT_W'(active_lists_reg);

    always_comb begin
        priority if (cfg_ext == '0) begin
            act_count = ACT_W'(1);
        end else if (cfg_ext > ACT_W'(MAX_LISTS)) begin
            act_count = ACT_W'(MAX_LISTS);
        end else begin
            act_count = cfg_ext;
        end
    end

    // Per-list queue state
    logic [CNT_W-1:0] cnt_reg   [MAX_LISTS];
    logic [PTR_W-1:0] ptr_reg   [MAX_LISTS];
    logic             ended_reg [MAX_LISTS];

    // Sequencer registers
    state_t           state_reg, state_next;
    logic [ACT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             ready_reg, ready_next;
    logic             cmp_pend_reg, cmp_pend_next;
    logic [LIST_W-1:0] cmp_list_reg, cmp_list_next;
    logic [RES_W-1:0] res_cnt_reg, res_cnt_next;
    status_t          pend_status_reg, pend_status_next;
    logic [2:0]       pend_list_reg, pend_list_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_value_reg, m_value_next;
    logic [2:0]       m_list_reg, m_list_next;
    logic             m_ovalid_reg, m_ovalid_next;
    logic             m_done_reg, m_done_next;
    status_t          m_status_reg, m_status_next;

    // Compare unit
    min_ctrl_t                    min_ctrl;
    logic                         min_any;
    logic [LIST_W-1:0]            min_list;
    logic signed [VALUE_BITS-1:0] min_value;
    logic [VALUE_BITS-1:0]        rd_data;

    // Accept check of the incoming item
    logic              accept;
    logic [LIST_W-1:0] lid_idx;
    status_t           rej;
    logic              take;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign lid_idx  = LIST_W'(in_list);

    always_comb begin
        priority if (ACT_W'(in_list) >= act_count) begin
            rej = STAT_INACTIVE;
        end else if (ended_reg[lid_idx]) begin
            rej = STAT_ENDED;
        end else if (in_has_value && (cnt_reg[lid_idx] == CNT_W'(QUEUE_DEPTH))) begin
            rej = STAT_FULL;
        end else begin
            rej = STAT_OK;
        end
    end

    assign take = accept && (rej == STAT_OK);

    // Write slot: read pointer plus fill count, wrapped once
    logic [PTR_W:0]   slot_sum;
    logic [PTR_W-1:0] wr_slot;
    logic [ADDR_W-1:0] wr_addr;

    assign slot_sum = (PTR_W + 1)'(ptr_reg[lid_idx]) + (PTR_W + 1)'(cnt_reg[lid_idx]);
    assign wr_slot  = (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
                    ? PTR_W'(slot_sum - (PTR_W + 1)'(QUEUE_DEPTH))
                    : PTR_W'(slot_sum);
    assign wr_addr  = ADDR_W'(lid_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_slot);

    // Scan read address of the current list's head
    logic [LIST_W-1:0] cur;
    logic [ADDR_W-1:0] rd_addr;

    assign cur     = scan_idx_reg[LIST_W-1:0];
    assign rd_addr = ADDR_W'(cur) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_reg[cur]);

    kwm_queue_mem #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (take && in_has_value),
        .wr_addr (wr_addr),
        .wr_data (VALUE_BITS'(in_value)),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign min_ctrl.start  = (state_reg == S_SCAN) && (scan_idx_reg == '0);
    assign min_ctrl.cmp_en = cmp_pend_reg;

    kwm_min_unit #(
        .VALUE_BITS (VALUE_BITS),
        .LIST_W     (LIST_W)
    ) u_min (
        .aclk       (aclk),
        .ctrl       (min_ctrl),
        .cmp_list   (cmp_list_reg),
        .cmp_value  ($signed(rd_data)),
        .any        (min_any),
        .best_list  (min_list),
        .best_value (min_value)
    );

    // Sequencer
    logic out_free;
    logic pop;
    logic clear_all;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        ready_next       = ready_reg;
        cmp_pend_next    = 1'b0;
        cmp_list_next    = cmp_list_reg;
        res_cnt_next     = res_cnt_reg;
        pend_status_next = pend_status_reg;
        pend_list_next   = pend_list_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_value_next     = m_value_reg;
        m_list_next      = m_list_reg;
        m_ovalid_next    = m_ovalid_reg;
        m_done_next      = m_done_reg;
        m_status_next    = m_status_reg;
        pop              = 1'b0;
        clear_all        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                // Take the item; scan next, or post a reject status first
                if (accept) begin
                    pend_status_next = rej;
                    pend_list_next   = in_list;
                    res_cnt_next     = '0;
                    scan_idx_next    = '0;
                    ready_next       = 1'b1;
                    state_next       = (rej == STAT_OK) ? S_SCAN : S_STATUS;
                end
            end
            S_STATUS: begin
                // Post the reject status ahead of any emission
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = '0;
                    m_list_next   = pend_list_reg;
                    m_ovalid_next = 1'b0;
                    m_done_next   = 1'b0;
                    m_status_next = pend_status_reg;
                    res_cnt_next  = RES_W'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one head read per cycle; note lists that block the merge
                cmp_pend_next = (cnt_reg[cur] != '0);
                cmp_list_next = cur;
                if ((cnt_reg[cur] == '0) && !ended_reg[cur]) begin
                    ready_next = 1'b0;
                end
                if (scan_idx_reg == act_count - ACT_W'(1)) begin
                    state_next = S_LAST;
                end else begin
                    scan_idx_next = scan_idx_reg + ACT_W'(1);
                end
            end
            S_LAST: begin
                // Last head goes through the compare unit
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (!ready_reg || (res_cnt_reg == RES_W'(MAX_RESULTS))) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_status_next = STAT_OK;
                    if (min_any) begin
                        // Emit the smallest head and rescan
                        m_value_next  = 32'(min_value);
                        m_list_next   = 3'(min_list);
                        m_ovalid_next = 1'b1;
                        m_done_next   = 1'b0;
                        pop           = 1'b1;
                        res_cnt_next  = res_cnt_reg + RES_W'(1);
                        scan_idx_next = '0;
                        ready_next    = 1'b1;
                        state_next    = S_SCAN;
                    end else begin
                        // All lists ended and drained: close the merge
                        m_value_next  = '0;
                        m_list_next   = '0;
                        m_ovalid_next = 1'b0;
                        m_done_next   = 1'b1;
                        clear_all     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            ready_reg    <= 1'b0;
            cmp_pend_reg <= 1'b0;
            res_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            ready_reg    <= ready_next;
            cmp_pend_reg <= cmp_pend_next;
            res_cnt_reg  <= res_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        cmp_list_reg    <= cmp_list_next;
        pend_status_reg <= pend_status_next;
        pend_list_reg   <= pend_list_next;
        m_value_reg     <= m_value_next;
        m_list_reg      <= m_list_next;
        m_ovalid_reg    <= m_ovalid_next;
        m_done_reg      <= m_done_next;
        m_status_reg    <= m_status_next;
    end

    // Queue pointers, fill counts and end flags
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int i = 0; i < MAX_LISTS; i++) begin
                cnt_reg[i]   <= '0;
                ptr_reg[i]   <= '0;
                ended_reg[i] <= 1'b0;
            end
        end else if (take) begin
            if (in_has_value) begin
                cnt_reg[lid_idx] <= cnt_reg[lid_idx] + CNT_W'(1);
            end
            if (in_eol) begin
                ended_reg[lid_idx] <= 1'b1;
            end
        end else if (pop) begin
            cnt_reg[min_list] <= cnt_reg[min_list] - CNT_W'(1);
            if (ptr_reg[min_list] == PTR_W'(QUEUE_DEPTH - 1)) begin
                ptr_reg[min_list] <= '0;
            end else begin
                ptr_reg[min_list] <= ptr_reg[min_list] + PTR_W'(1);
            end
        end
    end

    // Result ports
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_list_reg, m_value_reg};
    assign m_tuser  = {m_status_reg, m_ovalid_reg};
    assign m_tlast  = m_done_reg;

endmodule

[rtl/core/kwm_checker.sv]
// Port-level checks of the k-way sorted merge, bound to the top level.
`timescale 1ns / 1ps

module kwm_port_checker
    import kwm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled item holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // One item at a time: input closes after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input stayed open after accept");

    // The merge end result carries no element and an ok status
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[0] && (m_tuser[2:1] == STAT_OK)
            && (m_tdata == '0))
        else $error("merge end result not clean");

    // A reject status carries no element
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:1] != STAT_OK) |-> !m_tuser[0] && !m_tlast)
        else $error("reject status with element");

    // An element goes out with ok status and not as the end
    a_elem_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == STAT_OK) && !m_tlast)
        else $error("element with bad status");

endmodule

bind k_way_sorted_merge kwm_port_checker u_kwm_port_checker (.*);

[verif/kwm_checker.sv]
// Scoreboard of the k-way sorted merge: tracks the list queues, predicts and checks results.
`timescale 1ns / 1ps

module kwm_checker
    import kwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,        // [2:0] list_id, [34:3] value, [39:35] zero
    input  logic        s_tuser,        // [0] has_value
    input  logic        s_tlast,        // end_of_list
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,        // [31:0] out_value, [34:32] source_list, [39:35] zero
    input  logic [2:0]  m_tuser,        // [0] out_valid, [2:1] status
    input  logic        m_tlast,        // merge_done
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          merges_seen,
    output int          rejects_seen,
    output logic        merge_busy,
    output logic [7:0]  open_mask
);

    localparam int LISTS = DEF_MAX_LISTS;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [2:0]         source_list;
        logic               out_valid;
        logic               merge_done;
        status_t            status;
    } merge_result_t;

    merge_result_t      merged_q[$];
    logic signed [31:0] list_store[LISTS][DEPTH];
    logic [2:0]         head_ptr[LISTS];
    logic [3:0]         fill[LISTS];
    logic               ended[LISTS];
    logic [3:0]         active_reg;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        merges_seen  = 0;
        rejects_seen = 0;
        merge_busy   = 1'b0;
        open_mask    = '0;
    end

    // Out-of-range register codes clamp to one list or to all lists
    function automatic int lane_count();
        if (active_reg == 4'd0) return 1;
        if (active_reg > LISTS) return LISTS;
        return int'(active_reg);
    endfunction

    function automatic merge_result_t make_result(logic signed [31:0] v, logic [2:0] src,
                                                  logic vld, logic done, status_t st);
        merge_result_t r;
        r.out_value   = v;
        r.source_list = src;
        r.out_valid   = vld;
        r.merge_done  = done;
        r.status      = st;
        return r;
    endfunction

    task automatic clear_lists();
        for (int l = 0; l < LISTS; l++) begin
            head_ptr[l] = '0;
            fill[l]     = '0;
            ended[l]    = 1'b0;
        end
    endtask

    // Apply one input item and queue the results it releases
    task automatic merge_step(input logic [2:0] lid, input logic hv,
                              input logic signed [31:0] val, input logic eol);
        int lanes;
        int produced;
        int best;
        int slot;
        bit all_ready;
        lanes    = lane_count();
        produced = 0;
        if (int'(lid) >= lanes) begin
            merged_q = {merged_q, make_result('0, lid, 1'b0, 1'b0, STAT_INACTIVE)};
            produced++;
        end else if (ended[lid]) begin
            merged_q = {merged_q, make_result('0, lid, 1'b0, 1'b0, STAT_ENDED)};
            produced++;
        end else if (hv && fill[lid] >= DEPTH) begin
            merged_q = {merged_q, make_result('0, lid, 1'b0, 1'b0, STAT_FULL)};
            produced++;
        end else begin
            if (hv) begin
                slot = (int'(head_ptr[lid]) + int'(fill[lid])) % DEPTH;
                list_store[lid][slot] = val;
                fill[lid]++;
            end
            if (eol) ended[lid] = 1'b1;
        end
        if (produced != 0) rejects_seen++;

        // Emit the smallest head while every active list has one or has ended
        while (produced < MAX_RESULTS) begin
            all_ready = 1'b1;
            best      = -1;
            for (int l = 0; l < lanes; l++) begin
                if (fill[l] == 0) begin
                    if (!ended[l]) all_ready = 1'b0;
                end else if (best < 0 ||
                             list_store[l][head_ptr[l]] < list_store[best][head_ptr[best]]) begin
                    best = l;
                end
            end
            if (!all_ready) break;
            if (best < 0) begin
                merged_q = {merged_q, make_result('0, 3'd0, 1'b0, 1'b1, STAT_OK)};
                clear_lists();
                break;
            end
            merged_q = {merged_q, make_result(list_store[best][head_ptr[best]], 3'(best),
                                              1'b1, 1'b0, STAT_OK)};
            head_ptr[best]++;
            fill[best]--;
            produced++;
        end
    endtask

    // Compare one result item with the oldest prediction
    task automatic check_result();
        merge_result_t want;
        merge_result_t got;
        got.out_value   = m_tdata[31:0];
        got.source_list = m_tdata[34:32];
        got.out_valid   = m_tuser[0];
        got.merge_done  = m_tlast;
        got.status      = status_t'(m_tuser[2:1]);
        results_seen++;
        if (got.merge_done === 1'b1) merges_seen++;
        if (merged_q.size() == 0) begin
            $error("result with none expected: out_value %0d source_list %0d",
                   got.out_value, got.source_list);
            fail_count++;
            return;
        end
        want = merged_q.pop_front();
        if (got.out_value !== want.out_value) begin
            $error("out_value expected %0d actual %0d", want.out_value, got.out_value);
            fail_count++;
        end
        if (got.source_list !== want.source_list) begin
            $error("source_list expected %0d actual %0d", want.source_list, got.source_list);
            fail_count++;
        end
        if (got.out_valid !== want.out_valid) begin
            $error("out_valid expected %0d actual %0d", want.out_valid, got.out_valid);
            fail_count++;
        end
        if (got.merge_done !== want.merge_done) begin
            $error("merge_done expected %0d actual %0d", want.merge_done, got.merge_done);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
        end
    endtask

    // Retire results first: a result never stems from the item taken at the same edge
    always @(posedge aclk) begin
        logic       busy_now;
        logic [7:0] open_now;
        if (!aresetn) begin
            merged_q.delete();
            clear_lists();
            active_reg = 4'd8;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_we) active_reg = cfg_wdata;
            if (s_tvalid && s_tready) merge_step(s_tdata[2:0], s_tuser, s_tdata[34:3], s_tlast);
        end
        busy_now = 1'b0;
        open_now = '0;
        for (int l = 0; l < LISTS; l++) begin
            if (l < lane_count()) begin
                if (ended[l] || fill[l] != 0) busy_now = 1'b1;
                if (!ended[l]) open_now[l] = 1'b1;
            end
        end
        merge_busy = busy_now;
        open_mask  = open_now;
        pending    = merged_q.size();
    end

endmodule

[verif/tb.sv]
// Top of the k-way sorted merge testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import kwm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 32;
    localparam int RANDOM_ITEMS = 200;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int         fail_count;
    int         pending;
    int         results_seen;
    int         merges_seen;
    int         rejects_seen;
    logic       merge_busy;
    logic [7:0] open_mask;

    int lanes      = 8;
    int items_sent = 0;
    int cycles     = 0;
    int ready_left = 0;
    bit steady_tx  = 1'b0;

    k_way_sorted_merge DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    kwm_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .merges_seen  (merges_seen),
        .rejects_seen (rejects_seen),
        .merge_busy   (merge_busy),
        .open_mask    (open_mask)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: runs of ready, short stalls, now and then a long one
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    m_tready   <= 1'b1;
                    ready_left = $urandom_range(1, 30);
                end
                6, 7, 8: begin
                    m_tready   <= 1'b0;
                    ready_left = $urandom_range(0, 2);
                end
                default: begin
                    m_tready   <= 1'b0;
                    ready_left = $urandom_range(15, 60);
                end
            endcase
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic push_item(input logic [2:0] lid, input logic hv,
                             input logic signed [31:0] val, input logic eol);
        int gap;
        gap = 0;
        if (!steady_tx) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap = 0;
                10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
                17, 18: gap = $urandom_range(4, 10);
                default: gap = $urandom_range(20, 50);
            endcase
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, lid};
        s_tuser  <= hv;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (hv || eol) items_sent++;
    endtask

    // Hold off until every predicted result has left, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_lanes(input logic [3:0] code);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lanes = (code == 4'd0) ? 1 : ((code > 4'd8) ? 8 : int'(code));
    endtask

    // End open lists until the block is back to an empty merge
    task automatic close_merge();
        int l;
        wait_drained();
        @(negedge aclk);
        while (merge_busy) begin
            l = 0;
            while (l < 7 && !open_mask[l]) l++;
            @(posedge aclk);
            push_item(3'(l), 1'b0, '0, 1'b1);
            wait_drained();
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    // One merge: sorted lists over the active lanes, interleaved, with some noise
    task automatic run_merge();
        int                 len[8];
        int                 sent[8];
        bit                 sep_end[8];
        logic signed [31:0] vals[8][12];
        longint             next_val;
        int unsigned        step_max;
        int                 left;
        int                 l;
        int                 i;
        int                 r;
        int                 vmode;
        bit                 major;
        left      = 0;
        vmode     = $urandom_range(0, 2);
        major     = ($urandom_range(0, 9) < 3);
        steady_tx = ($urandom_range(0, 3) == 0);
        for (l = 0; l < 8; l++) begin
            len[l]     = 0;
            sent[l]    = 0;
            sep_end[l] = 1'b0;
        end
        for (l = 0; l < lanes; l++) begin
            r = $urandom_range(0, 19);
            if (r == 0) len[l] = 0;
            else if (r < 17) len[l] = $urandom_range(1, 5);
            else if (r < 19) len[l] = $urandom_range(6, 8);
            else len[l] = $urandom_range(9, 12);
            // Narrow ranges force ties across lists; the wide one sweeps every bit
            case (vmode)
                0: begin
                    next_val = $urandom_range(0, 3);
                    step_max = 1;
                end
                1: begin
                    next_val = longint'($signed($urandom));
                    if ($urandom_range(0, 3) == 0) next_val = VAL_MIN;
                    step_max = 32'h3fff_ffff;
                end
                default: begin
                    next_val = longint'($urandom_range(0, 200)) - 100;
                    step_max = 20;
                end
            endcase
            for (i = 0; i < len[l]; i++) begin
                if (next_val > VAL_MAX) next_val = VAL_MAX;
                vals[l][i] = next_val[31:0];
                next_val   = next_val + $urandom_range(0, step_max);
            end
            sep_end[l] = (len[l] == 0) || ($urandom_range(0, 3) == 0);
            left       = left + len[l] + sep_end[l];
        end

        while (left > 0) begin
            if ($urandom_range(0, 24) == 0) wait_drained();
            // Drop in a stray item now and then
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0 && lanes < 8) begin
                    push_item(3'($urandom_range(lanes, 7)), 1'($urandom), $urandom,
                              1'($urandom));
                end else if (r == 1) begin
                    l = $urandom_range(0, lanes - 1);
                    if (sent[l] == len[l] + sep_end[l])
                        push_item(3'(l), 1'b1, $urandom, 1'($urandom));
                end else begin
                    push_item(3'($urandom_range(0, lanes - 1)), 1'b0, $urandom, 1'b0);
                end
            end
            l = major ? 0 : $urandom_range(0, lanes - 1);
            while (sent[l] == len[l] + sep_end[l]) l = (l + 1) % lanes;
            i = sent[l];
            if (i < len[l]) push_item(3'(l), 1'b1, vals[l][i], !sep_end[l] && i == len[l] - 1);
            else push_item(3'(l), 1'b0, $urandom, 1'b1);
            sent[l]++;
            left--;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Two lists: bare item, inactive list, value extremes, ended list, bare end
        set_lanes(4'd2);
        push_item(3'd0, 1'b0, 32'sd0, 1'b0);
        push_item(3'd5, 1'b1, 32'sd7, 1'b0);
        push_item(3'd0, 1'b1, VAL_MIN, 1'b0);
        push_item(3'd1, 1'b1, VAL_MAX, 1'b0);
        push_item(3'd0, 1'b1, 32'sd5, 1'b1);
        push_item(3'd0, 1'b1, 32'sd9, 1'b0);
        push_item(3'd1, 1'b0, 32'sd0, 1'b1);

        // Code zero acts as a single list
        set_lanes(4'd0);
        push_item(3'd1, 1'b1, 32'sd3, 1'b0);
        push_item(3'd0, 1'b1, 32'sd3, 1'b1);

        // Code above the list count: overfill one queue, tie on equal values
        set_lanes(4'd15);
        for (int i = 0; i < 9; i++) push_item(3'd0, 1'b1, 32'sd4, i == 8);
        push_item(3'd3, 1'b1, 32'sd4, 1'b1);
        for (int l = 1; l < 8; l++) begin
            if (l != 3) push_item(3'(l), 1'b0, 32'sd0, 1'b1);
        end

        // Shrink the list count mid-merge; list 3 keeps an element that must vanish
        set_lanes(4'd3);
        push_item(3'd0, 1'b0, 32'sd0, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: set_lanes(4'd0);
                    1: set_lanes(4'd15);
                    2: set_lanes(4'd8);
                    3: set_lanes(4'd1);
                    4: set_lanes(4'($urandom_range(9, 15)));
                    default: set_lanes(4'($urandom_range(2, 7)));
                endcase
            end
            run_merge();
            close_merge();
        end

        wait_drained();
        @(negedge aclk);
        $display("Covered %0d random items over list counts 1 to 8, plus directed extremes,",
                 items_sent);
        $display("ties and rejections; %0d results checked, %0d merges, %0d rejected items.",
                 results_seen, merges_seen, rejects_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/kwm_pkg.sv
rtl/core/kwm_queue_mem.sv
rtl/core/kwm_min_unit.sv
rtl/core/k_way_sorted_merge.sv
rtl/core/kwm_checker.sv
verif/kwm_checker.sv
verif/tb.sv
